>>> rtl/core/rc6d_pkg.sv
// Package for the RC6 infrared pulse decoder: register indexes, reset values,
// the configuration bundle and the classified edge record.
// No dependencies.
package rc6d_pkg;

    localparam int LEAD_BITS = 10;
    localparam int THR_BITS  = 8;
    localparam int RAW_BITS  = 32;
    localparam int BYTE_BITS = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 10;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LEAD_MARK_MIN    = 3'd0,
        REG_LEAD_MARK_MAX    = 3'd1,
        REG_LEAD_SPACE_MIN   = 3'd2,
        REG_LEAD_SPACE_MAX   = 3'd3,
        REG_DOUBLE_THRESHOLD = 3'd4,
        REG_TRIPLE_THRESHOLD = 3'd5,
        REG_MAX_WIDTH        = 3'd6
    } cfg_index_t;

    localparam logic [LEAD_BITS-1:0] RST_LEAD_MARK_MIN  = 10'd75;
    localparam logic [LEAD_BITS-1:0] RST_LEAD_MARK_MAX  = 10'd90;
    localparam logic [LEAD_BITS-1:0] RST_LEAD_SPACE_MIN = 10'd23;
    localparam logic [LEAD_BITS-1:0] RST_LEAD_SPACE_MAX = 10'd32;
    localparam logic [THR_BITS-1:0]  RST_DOUBLE_THR     = 8'd23;
    localparam logic [THR_BITS-1:0]  RST_TRIPLE_THR     = 8'd35;
    localparam logic [THR_BITS-1:0]  RST_MAX_WIDTH      = 8'd50;

    typedef struct packed {
        logic [LEAD_BITS-1:0] lead_mark_lo;
        logic [LEAD_BITS-1:0] lead_mark_hi;
        logic [LEAD_BITS-1:0] lead_space_lo;
        logic [LEAD_BITS-1:0] lead_space_hi;
        logic [THR_BITS-1:0]  double_thr;
        logic [THR_BITS-1:0]  triple_thr;
        logic [THR_BITS-1:0]  max_width;
    } cfg_t;

    // One classified edge, as handed from the front end to the back end.
    typedef struct packed {
        logic       first;     // restart the message before this edge
        logic       lead_bad;  // leader outside a window (valid with first)
        logic       skip;      // one of the two leading edges, not decoded
        logic [1:0] slots;     // half-bit slots spanned, 1 to 3
        logic       too_wide;  // non-final edge longer than max_width
        logic       last;      // final edge, report a result
    } edge_rec_t;

endpackage

>>> rtl/core/rc6d_front.sv
// Front end of the RC6 decoder: checks the leader and classifies each edge.
// Depends on rc6d_pkg.
module rc6d_front #(
    parameter int TICK_BITS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rc6d_pkg::cfg_t                        cfg,
    input  logic                                  in_take,
    input  logic [rc6d_pkg::LEAD_BITS-1:0]        lead_mark,
    input  logic [rc6d_pkg::LEAD_BITS-1:0]        lead_space,
    input  logic [TICK_BITS-1:0]                  duration,
    input  logic                                  first_edge,
    input  logic                                  last_edge,
    output rc6d_pkg::edge_rec_t                   rec
);
    import rc6d_pkg::*;

    localparam int CMP_W = (TICK_BITS > THR_BITS) ? TICK_BITS : THR_BITS;

    logic [1:0] edge_index_reg, edge_index_next;
    logic [1:0] idx_base;
    logic       over_double, over_triple, over_max;

    assign idx_base    = first_edge ? 2'd0 : edge_index_reg;
    assign over_double = CMP_W'(duration) > CMP_W'(cfg.double_thr);
    assign over_triple = CMP_W'(duration) > CMP_W'(cfg.triple_thr);
    assign over_max    = CMP_W'(duration) > CMP_W'(cfg.max_width);

    always_comb begin
        edge_index_next = (idx_base == 2'd2) ? idx_base : idx_base + 2'd1;
        rec.first    = first_edge;
        rec.lead_bad = (lead_mark < cfg.lead_mark_lo) || (lead_mark > cfg.lead_mark_hi) ||
                       (lead_space < cfg.lead_space_lo) || (lead_space > cfg.lead_space_hi);
        rec.skip     = (idx_base != 2'd2);
        rec.slots    = 2'd1 + 2'(over_double) + 2'(over_triple);
        rec.too_wide = over_max && !last_edge;
        rec.last     = last_edge;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_index_reg <= 2'd0;
        end else if (in_take) begin
            edge_index_reg <= edge_index_next;
        end
    end

endmodule

>>> rtl/core/rc6d_queue.sv
// Two-entry queue of classified edges between front and back end.
// Depends on rc6d_pkg.
module rc6d_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rc6d_pkg::edge_rec_t push_rec,
    output logic                full,
    input  logic                pop,
    output rc6d_pkg::edge_rec_t pop_rec,
    output logic                not_empty
);
    import rc6d_pkg::*;

    edge_rec_t  entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_rec   = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push || pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

>>> rtl/core/rc6d_back.sv
// Back end of the RC6 decoder: expands edges into half-bit slots, shifts the
// line level into the word and registers the result. Depends on rc6d_pkg.
module rc6d_back #(
    parameter int WORD_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               rec_valid,
    input  rc6d_pkg::edge_rec_t                rec,
    output logic                               rec_take,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               valid_res,
    output logic [rc6d_pkg::RAW_BITS-1:0]      raw_bits,
    output logic [rc6d_pkg::BYTE_BITS-1:0]     address_byte,
    output logic [rc6d_pkg::BYTE_BITS-1:0]     command_byte
);
    import rc6d_pkg::*;

    localparam int RAW_W = (WORD_BITS < RAW_BITS) ? WORD_BITS : RAW_BITS;

    logic [WORD_BITS-1:0] word_reg, word_next, word_base;
    logic                 parity_reg, parity_next, parity_base;
    logic                 level_reg, level_next, level_base;
    logic                 failed_reg, failed_next, failed_base;
    logic [1:0]           shifts;

    logic                 out_valid_reg;
    logic                 valid_res_reg;
    logic [RAW_BITS-1:0]  raw_bits_reg;
    logic [BYTE_BITS-1:0] address_reg, command_reg;

    // Take a new edge whenever the result register is free or being drained.
    assign rec_take = rec_valid && (!out_valid_reg || out_ready);

    always_comb begin
        word_base   = rec.first ? '0   : word_reg;
        parity_base = rec.first ? 1'b0 : parity_reg;
        level_base  = rec.first ? 1'b1 : level_reg;
        failed_base = rec.first ? rec.lead_bad : failed_reg;

        // Odd slots shift in the level: count them from the starting parity.
        case (rec.slots)
            2'd2:    shifts = 2'd1;
            2'd3:    shifts = 2'd1 + 2'(parity_base);
            default: shifts = 2'(parity_base);
        endcase

        word_next   = word_base;
        parity_next = parity_base;
        level_next  = level_base;
        failed_next = failed_base;
        if (!rec.skip) begin
            case (shifts)
                2'd1:    word_next = {word_base[WORD_BITS-2:0], level_base};
                2'd2:    word_next = {word_base[WORD_BITS-3:0], level_base, level_base};
                default: word_next = word_base;
            endcase
            parity_next = parity_base ^ rec.slots[0];
            level_next  = ~level_base;
            failed_next = failed_base | rec.too_wide;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg      <= '0;
            parity_reg    <= 1'b0;
            level_reg     <= 1'b1;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rec_take) begin
                word_reg   <= word_next;
                parity_reg <= parity_next;
                level_reg  <= level_next;
                failed_reg <= failed_next;
            end
            if (rec_take && rec.last) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_take && rec.last) begin
            valid_res_reg <= !failed_next;
            raw_bits_reg  <= failed_next ? '0 : RAW_BITS'(word_next[RAW_W-1:0]);
            address_reg   <= failed_next ? '0 : word_next[15:8];
            command_reg   <= failed_next ? '0 : word_next[7:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign valid_res    = valid_res_reg;
    assign raw_bits     = raw_bits_reg;
    assign address_byte = address_reg;
    assign command_byte = command_reg;

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !valid_res_reg |->
            raw_bits_reg == '0 && address_reg == '0 && command_reg == '0)
        else $error("failed result carries data");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(rec_take && rec.last))
        else $error("result without a final edge");

    a_bytes_match: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> raw_bits_reg[15:8] == address_reg && raw_bits_reg[7:0] == command_reg)
        else $error("address or command byte out of step with raw bits");

endmodule

>>> rtl/core/rc6_ir_pulse_decoder.sv
// RC6 infrared pulse decoder, top level: configuration registers, front end,
// edge queue and back end. Depends on rc6d_pkg, rc6d_front, rc6d_queue, rc6d_back.
// Throughput: one edge per cycle while the queue has room; the front end classifies
// an edge in the cycle it is accepted, the back end retires one queued edge per
// cycle unless a result waits, and a final edge goes via queue and result register.
// Reset (aresetn low, synchronous): registers return to defaults, queue empties.
module rc6_ir_pulse_decoder #(
    parameter int WORD_BITS = 32,
    parameter int TICK_BITS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // Input edge channel.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // tdata, low bit up: lead_mark[9:0], lead_space[9:0], duration, zero pad
    input  logic [((2*rc6d_pkg::LEAD_BITS+TICK_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                                  s_tuser,   // first_edge
    input  logic                                  s_tlast,   // last_edge

    // Result channel.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // tdata, low bit up: raw_bits[31:0], address_byte[7:0], command_byte[7:0]
    output logic [rc6d_pkg::RAW_BITS+2*rc6d_pkg::BYTE_BITS-1:0] m_tdata,
    output logic                                  m_tuser,   // valid_res

    // Configuration write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rc6d_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [rc6d_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import rc6d_pkg::*;

    localparam int DUR_LO = 2 * LEAD_BITS;

    cfg_t       cfg_reg;
    edge_rec_t  front_rec, queue_rec;
    logic       in_take, q_full, q_not_empty, back_take;
    logic       valid_res;
    logic [RAW_BITS-1:0]  raw_bits;
    logic [BYTE_BITS-1:0] address_byte, command_byte;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lead_mark_lo  <= RST_LEAD_MARK_MIN;
            cfg_reg.lead_mark_hi  <= RST_LEAD_MARK_MAX;
            cfg_reg.lead_space_lo <= RST_LEAD_SPACE_MIN;
            cfg_reg.lead_space_hi <= RST_LEAD_SPACE_MAX;
            cfg_reg.double_thr    <= RST_DOUBLE_THR;
            cfg_reg.triple_thr    <= RST_TRIPLE_THR;
            cfg_reg.max_width     <= RST_MAX_WIDTH;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                REG_LEAD_MARK_MIN:    cfg_reg.lead_mark_lo  <= cfg_data[LEAD_BITS-1:0];
                REG_LEAD_MARK_MAX:    cfg_reg.lead_mark_hi  <= cfg_data[LEAD_BITS-1:0];
                REG_LEAD_SPACE_MIN:   cfg_reg.lead_space_lo <= cfg_data[LEAD_BITS-1:0];
                REG_LEAD_SPACE_MAX:   cfg_reg.lead_space_hi <= cfg_data[LEAD_BITS-1:0];
                REG_DOUBLE_THRESHOLD: cfg_reg.double_thr    <= cfg_data[THR_BITS-1:0];
                REG_TRIPLE_THRESHOLD: cfg_reg.triple_thr    <= cfg_data[THR_BITS-1:0];
                REG_MAX_WIDTH:        cfg_reg.max_width     <= cfg_data[THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Accept an edge whenever the queue has room.
    assign s_tready = !q_full;
    assign in_take  = s_tvalid && s_tready;

    rc6d_front #(
        .TICK_BITS (TICK_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_take    (in_take),
        .lead_mark  (s_tdata[LEAD_BITS-1:0]),
        .lead_space (s_tdata[2*LEAD_BITS-1:LEAD_BITS]),
        .duration   (s_tdata[DUR_LO+TICK_BITS-1:DUR_LO]),
        .first_edge (s_tuser),
        .last_edge  (s_tlast),
        .rec        (front_rec)
    );

    // The queue lets the front keep taking edges while a result waits.
    rc6d_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_take),
        .push_rec  (front_rec),
        .full      (q_full),
        .pop       (back_take),
        .pop_rec   (queue_rec),
        .not_empty (q_not_empty)
    );

    rc6d_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rec_valid    (q_not_empty),
        .rec          (queue_rec),
        .rec_take     (back_take),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .valid_res    (valid_res),
        .raw_bits     (raw_bits),
        .address_byte (address_byte),
        .command_byte (command_byte)
    );

    assign m_tdata = {command_byte, address_byte, raw_bits};
    assign m_tuser = valid_res;

endmodule

>>> tb/sv/rc6_decode_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the RC6 infrared pulse decoder: watches the edge, result and
// register channels, decodes each edge itself and compares every result.
// Depends on rc6d_pkg.
module rc6_decode_checker #(
    parameter int WORD_BITS   = 32,
    parameter int TICK_BITS   = 8,
    parameter int S_DATA_BITS = 32
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    input  logic                                     s_tready,
    input  logic [S_DATA_BITS-1:0]                   s_tdata,
    input  logic                                     s_tuser,
    input  logic                                     s_tlast,
    input  logic                                     m_tvalid,
    input  logic                                     m_tready,
    input  logic [rc6d_pkg::RAW_BITS+2*rc6d_pkg::BYTE_BITS-1:0] m_tdata,
    input  logic                                     m_tuser,
    input  logic                                     cfg_valid,
    input  logic                                     cfg_ready,
    input  logic [rc6d_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [rc6d_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    output int                                       fail_count,
    output int                                       pending,
    output int                                       results_checked,
    output int                                       decoded_messages
);
    import rc6d_pkg::*;

    typedef struct packed {
        logic                 msg_ok;
        logic [RAW_BITS-1:0]  raw;
        logic [BYTE_BITS-1:0] address;
        logic [BYTE_BITS-1:0] command;
    } rc6_result_t;

    cfg_t                 regs;
    logic [WORD_BITS-1:0] shift_word;
    logic                 half_slot;
    logic [1:0]           edge_count;
    logic                 level;
    logic                 msg_failed;
    rc6_result_t          expected_results[$];

    initial begin
        fail_count       = 0;
        pending          = 0;
        results_checked  = 0;
        decoded_messages = 0;
    end

    task automatic clear_message();
        shift_word = '0;
        half_slot  = 1'b0;
        edge_count = 2'd0;
        level      = 1'b1;
        msg_failed = 1'b0;
    endtask

    // Shift the line level in on every second half-bit slot.
    task automatic take_slot();
        if (half_slot)
            shift_word = {shift_word[WORD_BITS-2:0], level};
        half_slot = ~half_slot;
    endtask

    task automatic decode_edge(input logic [LEAD_BITS-1:0] mark,
                               input logic [LEAD_BITS-1:0] space,
                               input logic [TICK_BITS-1:0] dur,
                               input logic is_first, input logic is_last);
        rc6_result_t res;
        if (is_first) begin
            clear_message();
            if (mark < regs.lead_mark_lo || mark > regs.lead_mark_hi ||
                space < regs.lead_space_lo || space > regs.lead_space_hi)
                msg_failed = 1'b1;
        end
        // The two leading edges are neither decoded nor width checked.
        if (edge_count < 2'd2) begin
            edge_count = edge_count + 2'd1;
        end else begin
            if (dur > regs.max_width && !is_last)
                msg_failed = 1'b1;
            if (dur > regs.triple_thr)
                take_slot();
            if (dur > regs.double_thr)
                take_slot();
            take_slot();
            level = ~level;
        end
        if (is_last) begin
            res = '0;
            if (!msg_failed) begin
                res.msg_ok  = 1'b1;
                res.raw     = shift_word[RAW_BITS-1:0];
                res.address = shift_word[15:8];
                res.command = shift_word[7:0];
            end
            expected_results.push_back(res);
        end
    endtask

    task automatic check_result(input rc6_result_t got);
        rc6_result_t want;
        if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%t: result with nothing outstanding: valid=%0d raw=%h addr=%h cmd=%h",
                         $realtime, got.msg_ok, got.raw, got.address, got.command);
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        if (want.msg_ok)
            decoded_messages++;
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%t: result mismatch: expected valid=%0d raw=%h addr=%h cmd=%h,",
                         $realtime, want.msg_ok, want.raw, want.address, want.command,
                         " got valid=%0d raw=%h addr=%h cmd=%h",
                         got.msg_ok, got.raw, got.address, got.command);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs.lead_mark_lo  = RST_LEAD_MARK_MIN;
            regs.lead_mark_hi  = RST_LEAD_MARK_MAX;
            regs.lead_space_lo = RST_LEAD_SPACE_MIN;
            regs.lead_space_hi = RST_LEAD_SPACE_MAX;
            regs.double_thr    = RST_DOUBLE_THR;
            regs.triple_thr    = RST_TRIPLE_THR;
            regs.max_width     = RST_MAX_WIDTH;
            clear_message();
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result({m_tuser, m_tdata[31:0], m_tdata[39:32], m_tdata[47:40]});
            // An edge taken on the same clock as a register write still sees
            // the old settings.
            if (s_tvalid && s_tready)
                decode_edge(s_tdata[LEAD_BITS-1:0], s_tdata[2*LEAD_BITS-1:LEAD_BITS],
                            s_tdata[2*LEAD_BITS+TICK_BITS-1:2*LEAD_BITS], s_tuser, s_tlast);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LEAD_MARK_MIN:    regs.lead_mark_lo  = cfg_data;
                    REG_LEAD_MARK_MAX:    regs.lead_mark_hi  = cfg_data;
                    REG_LEAD_SPACE_MIN:   regs.lead_space_lo = cfg_data;
                    REG_LEAD_SPACE_MAX:   regs.lead_space_hi = cfg_data;
                    REG_DOUBLE_THRESHOLD: regs.double_thr    = cfg_data[THR_BITS-1:0];
                    REG_TRIPLE_THRESHOLD: regs.triple_thr    = cfg_data[THR_BITS-1:0];
                    REG_MAX_WIDTH:        regs.max_width     = cfg_data[THR_BITS-1:0];
                    default: ;
                endcase
            end
        end
        pending = expected_results.size();
    end

endmodule

>>> tb/sv/tb_rc6_ir_pulse_decoder.sv
`timescale 1ns / 1ps
// Top of the RC6 pulse decoder testbench: clock, reset, edge stimulus, register
// settings, result back-pressure and the verdict. Depends on rc6d_pkg,
// rc6_ir_pulse_decoder and rc6_decode_checker.
module tb_rc6_ir_pulse_decoder;
    import rc6d_pkg::*;

    localparam int WORD_BITS   = 32;
    localparam int TICK_BITS   = 8;
    localparam int S_DATA_BITS = ((2*LEAD_BITS+TICK_BITS+7)/8)*8;
    localparam int PHASE_EDGES = 230;
    localparam int SETTLE_CYCLES = 16;
    // Index past the last register; writes to it must change nothing.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_INDEX = 3'd7;

    logic                                  aclk = 1'b0;
    logic                                  aresetn;
    logic                                  s_tvalid;
    logic                                  s_tready;
    // lead_mark[9:0], lead_space[19:10], duration[27:20], zero pad (low bit up)
    logic [S_DATA_BITS-1:0]                s_tdata;
    logic                                  s_tuser;   // first_edge
    logic                                  s_tlast;   // last_edge
    logic                                  m_tvalid;
    logic                                  m_tready;
    // raw_bits[31:0], address_byte[39:32], command_byte[47:40] (low bit up)
    logic [RAW_BITS+2*BYTE_BITS-1:0]       m_tdata;
    logic                                  m_tuser;   // valid_res
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [CFG_INDEX_BITS-1:0]             cfg_index;
    logic [CFG_DATA_BITS-1:0]              cfg_data;

    int fail_count;
    int pending;
    int results_checked;
    int decoded_messages;

    // Stimulus-side copy of the register settings, used to aim durations and
    // leaders at the live windows.
    cfg_t stim_cfg;
    int   edges_sent;
    int   phase_count;
    int   stall_mode;
    bit   use_gaps;
    int   burst_left;
    bit   stall_hold;
    int   stall_run;

    rc6_ir_pulse_decoder #(
        .WORD_BITS (WORD_BITS),
        .TICK_BITS (TICK_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rc6_decode_checker #(
        .WORD_BITS   (WORD_BITS),
        .TICK_BITS   (TICK_BITS),
        .S_DATA_BITS (S_DATA_BITS)
    ) u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .pending          (pending),
        .results_checked  (results_checked),
        .decoded_messages (decoded_messages)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result back-pressure: always ready, random stalls, or long
    // alternating stretches of stall and accept.
    always @(negedge aclk) begin
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_run == 0) begin
                    stall_hold = ~stall_hold;
                    stall_run  = stall_hold ? int'($urandom_range(1, 12))
                                            : int'($urandom_range(1, 6));
                end else begin
                    stall_run--;
                end
                m_tready <= !stall_hold;
            end
        endcase
    end

    // Drive one edge transaction and hold it until accepted. Leave tvalid high
    // on return so back-to-back edges see no bubble; drop it only for a gap.
    task automatic send_edge(input logic [LEAD_BITS-1:0] mark,
                             input logic [LEAD_BITS-1:0] space,
                             input logic [TICK_BITS-1:0] dur,
                             input logic is_first, input logic is_last);
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_BITS'({dur, space, mark});
        s_tuser  <= is_first;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        edges_sent++;
        @(negedge aclk);
        if (use_gaps) begin
            burst_left--;
            if (burst_left <= 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
                burst_left = int'($urandom_range(1, 24));
            end
        end
    endtask

    // Hold one register write until accepted; the caller drops cfg_valid.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic load_registers(input logic [CFG_DATA_BITS-1:0] mark_lo, mark_hi,
                                  input logic [CFG_DATA_BITS-1:0] space_lo, space_hi,
                                  input logic [CFG_DATA_BITS-1:0] dbl, trp, widest);
        write_reg(REG_LEAD_MARK_MIN, mark_lo);
        write_reg(REG_LEAD_MARK_MAX, mark_hi);
        write_reg(REG_LEAD_SPACE_MIN, space_lo);
        write_reg(REG_LEAD_SPACE_MAX, space_hi);
        write_reg(REG_DOUBLE_THRESHOLD, dbl);
        write_reg(REG_TRIPLE_THRESHOLD, trp);
        write_reg(REG_MAX_WIDTH, widest);
        cfg_valid <= 1'b0;
        stim_cfg.lead_mark_lo  = mark_lo;
        stim_cfg.lead_mark_hi  = mark_hi;
        stim_cfg.lead_space_lo = space_lo;
        stim_cfg.lead_space_hi = space_hi;
        stim_cfg.double_thr    = dbl[THR_BITS-1:0];
        stim_cfg.triple_thr    = trp[THR_BITS-1:0];
        stim_cfg.max_width     = widest[THR_BITS-1:0];
    endtask

    // Stop sending, wait for every outstanding result, then let the edge
    // queue empty of trailing edges that report nothing.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [LEAD_BITS-1:0] in_window(input int lo, input int hi);
        if (lo > hi)
            return LEAD_BITS'($urandom_range(0, 1023));
        return LEAD_BITS'($urandom_range(lo, hi));
    endfunction

    // Duration that spans the requested number of half-bit slots under the
    // current thresholds; any duration when that band is empty.
    function automatic logic [TICK_BITS-1:0] pick_duration(input int slots);
        int lo;
        int hi;
        case (slots)
            1: begin
                lo = 0;
                hi = int'(stim_cfg.double_thr);
            end
            2: begin
                lo = int'(stim_cfg.double_thr) + 1;
                hi = int'(stim_cfg.triple_thr);
            end
            default: begin
                lo = int'(stim_cfg.triple_thr) + 1;
                hi = int'(stim_cfg.max_width);
            end
        endcase
        if (lo > hi)
            return TICK_BITS'($urandom_range(0, 255));
        return TICK_BITS'($urandom_range(lo, hi));
    endfunction

    // One message with random content. Most are well formed; the rest lack
    // the start flag, stop without a final edge, or carry noisy widths.
    task automatic send_message();
        int len;
        int kind;
        int n;
        logic [LEAD_BITS-1:0] mark;
        logic [LEAD_BITS-1:0] space;
        logic [TICK_BITS-1:0] dur;
        logic is_first;
        logic is_last;
        len  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 4))
                                           : int'($urandom_range(6, 36));
        kind = int'($urandom_range(0, 9));
        for (n = 0; n < len; n++) begin
            is_first = (n == 0) && (kind != 7);
            is_last  = (n == len - 1) && (kind != 8);
            if (is_first && $urandom_range(0, 7) != 0) begin
                mark  = in_window(int'(stim_cfg.lead_mark_lo), int'(stim_cfg.lead_mark_hi));
                space = in_window(int'(stim_cfg.lead_space_lo), int'(stim_cfg.lead_space_hi));
            end else begin
                mark  = LEAD_BITS'($urandom_range(0, 1023));
                space = LEAD_BITS'($urandom_range(0, 1023));
            end
            if (n < 2 || (kind == 9 && $urandom_range(0, 3) == 0))
                dur = TICK_BITS'($urandom_range(0, 255));
            else
                dur = pick_duration(int'($urandom_range(1, 3)));
            // A final edge may run long without failing the message.
            if (is_last && $urandom_range(0, 3) == 0)
                dur = TICK_BITS'($urandom_range(0, 255));
            send_edge(mark, space, dur, is_first, is_last);
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        s_tlast    = 1'b0;
        m_tready   = 1'b1;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        edges_sent = 0;
        stall_mode = 0;
        use_gaps   = 1'b0;
        stall_hold = 1'b0;
        stall_run  = 0;
        burst_left = int'($urandom_range(1, 24));
        stim_cfg   = {RST_LEAD_MARK_MIN, RST_LEAD_MARK_MAX, RST_LEAD_SPACE_MIN,
                      RST_LEAD_SPACE_MAX, RST_DOUBLE_THR, RST_TRIPLE_THR, RST_MAX_WIDTH};

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed edges under the reset settings. Start without any start
        // flag: decoding continues from the reset state.
        stall_mode = 2;
        send_edge(10'd0, 10'd0, 8'd0, 1'b0, 1'b0);
        send_edge(10'd1023, 10'd1023, 8'd255, 1'b0, 1'b0);
        send_edge(10'd0, 10'd0, 8'd23, 1'b0, 1'b0);
        send_edge(10'd0, 10'd0, 8'd24, 1'b0, 1'b0);
        send_edge(10'd0, 10'd0, 8'd255, 1'b0, 1'b1);
        // Leader on the lower window edges; widths on the triple and max-width threshold edges.
        send_edge(10'd75, 10'd23, 8'd200, 1'b1, 1'b0);
        send_edge(10'd0, 10'd0, 8'd7, 1'b0, 1'b0);
        send_edge(10'd0, 10'd0, 8'd35, 1'b0, 1'b0);
        send_edge(10'd0, 10'd0, 8'd36, 1'b0, 1'b0);
        send_edge(10'd0, 10'd0, 8'd50, 1'b0, 1'b0);
        send_edge(10'd0, 10'd0, 8'd12, 1'b0, 1'b1);
        // Keep extending after the final edge; report again.
        send_edge(10'd0, 10'd0, 8'd30, 1'b0, 1'b0);
        send_edge(10'd0, 10'd0, 8'd40, 1'b0, 1'b1);
        // Upper leader edges, then an over-long inner edge fails the message.
        send_edge(10'd90, 10'd32, 8'd0, 1'b1, 1'b0);
        send_edge(10'd0, 10'd0, 8'd0, 1'b0, 1'b0);
        send_edge(10'd0, 10'd0, 8'd51, 1'b0, 1'b0);
        send_edge(10'd0, 10'd0, 8'd10, 1'b0, 1'b1);
        // Leaders just outside each window.
        send_edge(10'd74, 10'd32, 8'd0, 1'b1, 1'b0);
        send_edge(10'd0, 10'd0, 8'd0, 1'b0, 1'b0);
        send_edge(10'd0, 10'd0, 8'd20, 1'b0, 1'b1);
        send_edge(10'd91, 10'd23, 8'd0, 1'b1, 1'b1);
        send_edge(10'd80, 10'd22, 8'd0, 1'b1, 1'b1);
        send_edge(10'd80, 10'd33, 8'd0, 1'b1, 1'b1);
        // Single-edge messages: a good one and one at full scale.
        send_edge(10'd80, 10'd25, 8'd0, 1'b1, 1'b1);
        send_edge(10'd1023, 10'd1023, 8'd255, 1'b1, 1'b1);

        // Random messages across several register settings.
        for (phase_count = 0; phase_count < 6; phase_count++) begin
            drain_results();
            case (phase_count)
                0: load_registers(10'd75, 10'd90, 10'd23, 10'd32, 10'd23, 10'd35, 10'd50);
                1: load_registers(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
                2: load_registers(10'd1023, 10'd1023, 10'd1023, 10'd1023,
                                  10'd255, 10'd255, 10'd255);
                // Thresholds out of order: each exceeded one still adds a slot.
                3: load_registers(10'd0, 10'd1023, 10'd0, 10'd1023, 10'd40, 10'd20, 10'd200);
                4: begin
                    // Full-width data on the narrow registers checks truncation.
                    write_reg(REG_SPARE_INDEX, CFG_DATA_BITS'($urandom_range(0, 1023)));
                    load_registers(CFG_DATA_BITS'($urandom_range(0, 80)),
                                   CFG_DATA_BITS'($urandom_range(60, 1023)),
                                   CFG_DATA_BITS'($urandom_range(0, 40)),
                                   CFG_DATA_BITS'($urandom_range(20, 1023)),
                                   CFG_DATA_BITS'($urandom_range(0, 1023)),
                                   CFG_DATA_BITS'($urandom_range(0, 1023)),
                                   CFG_DATA_BITS'($urandom_range(0, 1023)));
                end
                default: load_registers(10'd40, 10'd60, 10'd10, 10'd20,
                                        10'd12, 10'd20, 10'd28);
            endcase
            stall_mode = phase_count % 3;
            use_gaps   = (phase_count != 0);
            begin : phase_body
                int phase_start;
                phase_start = edges_sent;
                while (edges_sent - phase_start < PHASE_EDGES)
                    send_message();
            end
        end

        drain_results();
        $display("Covered %0d edge transactions under the reset and six written settings,",
                 edges_sent);
        $display("with sender gaps and result stalls; %0d results compared, %0d decoded.",
                 results_checked, decoded_messages);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
